[rtl/core/utf8d_pkg.sv]
// utf8d_pkg: shared types and constants for the UTF-8 to 16-bit code unit decoder.
// No dependencies; imported by utf8d_decode, utf8_to_ucs2_decoder and the testbench.
`default_nettype none

package utf8d_pkg;

  // Lead byte classification masks and patterns
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;

  // Continuation bytes still expected
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // Decoder sequence state
  typedef struct packed {
    logic [1:0]  pending;
    logic [15:0] partial;
    logic        halted;
  } dec_state_t;

  // One result transaction
  typedef struct packed {
    logic [15:0] code_unit;
    logic        char_valid;
    logic        string_end;
    logic        stopped;
  } dec_result_t;

endpackage : utf8d_pkg

`default_nettype wire

[rtl/core/utf8d_decode.sv]
// utf8d_decode: per-byte decode step, next sequence state and optional result.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_decode (
  input  utf8d_pkg::dec_state_t  state_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   final_byte_i,
  output utf8d_pkg::dec_state_t  state_o,
  output utf8d_pkg::dec_result_t result_o,
  output logic                   result_valid_o
);
  import utf8d_pkg::*;

  logic        do_stop;
  logic        do_char;
  logic [15:0] char_val;
  dec_state_t  step_state;

  // Classify the byte against the current sequence state
  always_comb begin
    step_state = state_i;
    do_stop    = 1'b0;
    do_char    = 1'b0;
    char_val   = 16'h0000;
    if (state_i.halted) begin
      // ignore bytes until the end of the string
      if (final_byte_i) begin
        step_state.halted  = 1'b0;
        step_state.pending = PEND_NONE;
        step_state.partial = 16'h0000;
      end
    end else if (state_i.pending == PEND_NONE) begin
      if ((data_byte_i & LEAD3_MASK) == LEAD3_PAT) begin
        if (final_byte_i) begin
          do_stop = 1'b1;
        end else begin
          step_state.partial = {data_byte_i[3:0], 12'h000};
          step_state.pending = PEND_TWO;
        end
      end else if ((data_byte_i & LEAD2_MASK) == LEAD2_PAT) begin
        if (final_byte_i) begin
          do_stop = 1'b1;
        end else begin
          step_state.partial = {5'b00000, data_byte_i[4:0], 6'b000000};
          step_state.pending = PEND_ONE;
        end
      end else if (!data_byte_i[7]) begin
        do_char  = 1'b1;
        char_val = {8'h00, data_byte_i};
      end else begin
        do_stop = 1'b1;
      end
    end else if ((data_byte_i & CONT_MASK) != CONT_PAT) begin
      do_stop = 1'b1;
    end else if (state_i.pending[1]) begin
      // middle byte of a three-byte sequence
      step_state.partial = state_i.partial | {4'h0, data_byte_i[5:0], 6'b000000};
      step_state.pending = PEND_ONE;
      do_stop            = final_byte_i;
    end else begin
      do_char  = 1'b1;
      char_val = state_i.partial | {10'b0000000000, data_byte_i[5:0]};
    end
  end

  // Resolve into result and next state; a zero character is a stop
  always_comb begin
    state_o        = step_state;
    result_o       = '0;
    result_valid_o = 1'b0;
    if (do_stop || (do_char && (char_val == 16'h0000))) begin
      state_o.pending     = PEND_NONE;
      state_o.partial     = 16'h0000;
      state_o.halted      = !final_byte_i;
      result_o.string_end = 1'b1;
      result_o.stopped    = 1'b1;
      result_valid_o      = 1'b1;
    end else if (do_char) begin
      state_o.pending     = PEND_NONE;
      state_o.partial     = 16'h0000;
      result_o.code_unit  = char_val;
      result_o.char_valid = 1'b1;
      result_o.string_end = final_byte_i;
      result_valid_o      = 1'b1;
    end
  end

endmodule : utf8d_decode

`default_nettype wire

[rtl/core/utf8_to_ucs2_decoder.sv]
// utf8_to_ucs2_decoder: top level; sequence state, output register and skid stage.
// Depends on utf8d_pkg and utf8d_decode.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   input   | in        | valid_i / stall_o   | data_byte_i, final_byte_i
//   result  | out       | valid_o / stall_i   | code_unit_o, char_valid_o, string_end_o,
//           |           |                     | stopped_o
//
// One byte per cycle while stall_o is low; a result goes to the output register or skid.
// The sequence state registers close a loop through the combinational decode step.
// A two-entry output (register plus skid) keeps input accepted while a result waits;
// stall_o rises only once both entries are full.
// Reset clears the sequence state and both output valid bits.
`default_nettype none

module utf8_to_ucs2_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] code_unit_o,
  output logic        char_valid_o,
  output logic        string_end_o,
  output logic        stopped_o
);
  import utf8d_pkg::*;

  dec_state_t  state_q, state_d;
  dec_result_t res;
  logic        res_valid;
  logic        in_fire;
  logic        out_fire;

  dec_result_t out_q;
  logic        out_valid_q;
  dec_result_t skid_q;
  logic        skid_valid_q;

  utf8d_decode u_decode (
    .state_i        (state_q),
    .data_byte_i    (data_byte_i),
    .final_byte_i   (final_byte_i),
    .state_o        (state_d),
    .result_o       (res),
    .result_valid_o (res_valid)
  );

  assign stall_o  = skid_valid_q;
  assign in_fire  = valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !stall_i;

  // Sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output register and skid valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_q <= in_fire && res_valid;
    end else if (in_fire && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_fire) begin
      if (in_fire && res_valid) begin
        out_q <= res;
      end
    end else if (in_fire && res_valid) begin
      skid_q <= res;
    end
  end

  assign valid_o      = out_valid_q;
  assign code_unit_o  = out_q.code_unit;
  assign char_valid_o = out_q.char_valid;
  assign string_end_o = out_q.string_end;
  assign stopped_o    = out_q.stopped;

`ifndef SYNTHESIS
  // skid entry only holds data behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid full with empty output register");

  // a delivered character is never zero
  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && char_valid_o) |-> (code_unit_o != 16'h0000))
    else $error("zero code unit delivered as character");

  // a stop ends the string and carries no character
  a_stop_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stopped_o) |-> (string_end_o && !char_valid_o && code_unit_o == 16'h0000))
    else $error("malformed stop result");

  // while halted, no sequence is in progress
  a_halt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.halted |-> (state_q.pending == PEND_NONE && state_q.partial == 16'h0000))
    else $error("sequence state left behind a stop");
`endif

endmodule : utf8_to_ucs2_decoder

`default_nettype wire

[tb/sv/tb_utf8_to_ucs2_decoder.sv]
// tb_utf8_to_ucs2_decoder: self-checking testbench for the UTF-8 to 16-bit code unit decoder.
// Depends on utf8d_pkg and utf8_to_ucs2_decoder; a directed table, then random strings, all
// checked against an in-line decoder model or a hand-typed expectation, with random idling on both channels.
module tb_utf8_to_ucs2_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int RANDOM_BYTES = 1050;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AFTER_UNITS = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_OFFSET = 600;
  localparam int TAIL_CYCLES = 8;

  // How a random string gets damaged
  typedef enum int {
    DAMAGE_NONE,
    DAMAGE_SWAP,
    DAMAGE_CUT,
    DAMAGE_ZERO,
    DAMAGE_NOISE
  } damage_e;

  // One input transaction, with an optional hand-typed expectation
  typedef struct {
    logic [7:0]  data;
    logic        fin;
    bit          known;
    dec_result_t want;
    bit          drain_first;
  } byte_xact_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        final_byte_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b1;
  logic [15:0] code_unit_o;
  logic        char_valid_o;
  logic        string_end_o;
  logic        stopped_o;

  byte_xact_t  byte_q[$];
  dec_result_t pending_units[$];

  // Decoder model state
  logic [1:0]  seq_pend;
  logic [15:0] seq_part;
  logic        seq_halted;

  int  bytes_taken;
  int  units_seen;
  int  err_count;
  int  idle_cycles;
  int  chars_seen;
  int  stops_seen;
  int  ignored_seen;
  int  backpressure_cycles;
  bit  all_sent;

  utf8_to_ucs2_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .data_byte_i (data_byte_i),
    .final_byte_i(final_byte_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .code_unit_o (code_unit_o),
    .char_valid_o(char_valid_o),
    .string_end_o(string_end_o),
    .stopped_o   (stopped_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------
  function automatic bit stop_unit(input logic fin, output dec_result_t r);
    seq_pend   = PEND_NONE;
    seq_part   = '0;
    seq_halted = !fin;
    r = '{code_unit: 16'h0000, char_valid: 1'b0, string_end: 1'b1, stopped: 1'b1};
    return 1'b1;
  endfunction

  function automatic bit char_unit(input logic [15:0] value, input logic fin,
                                   output dec_result_t r);
    // A decoded zero aborts like any other error
    if (value == 16'h0000) return stop_unit(fin, r);
    seq_pend = PEND_NONE;
    seq_part = '0;
    r = '{code_unit: value, char_valid: 1'b1, string_end: fin, stopped: 1'b0};
    return 1'b1;
  endfunction

  function automatic bit decode_step(input logic [7:0] b, input logic fin,
                                     output dec_result_t r);
    r = '0;
    // Skip to the end of a string that has already stopped
    if (seq_halted) begin
      if (fin) begin
        seq_halted = 1'b0;
        seq_pend   = PEND_NONE;
        seq_part   = '0;
      end
      return 1'b0;
    end
    // Lead byte
    if (seq_pend == PEND_NONE) begin
      if ((b & LEAD3_MASK) == LEAD3_PAT) begin
        if (fin) return stop_unit(fin, r);
        seq_part = {b[3:0], 12'h000};
        seq_pend = PEND_TWO;
        return 1'b0;
      end
      if ((b & LEAD2_MASK) == LEAD2_PAT) begin
        if (fin) return stop_unit(fin, r);
        seq_part = {5'b00000, b[4:0], 6'b000000};
        seq_pend = PEND_ONE;
        return 1'b0;
      end
      if (!b[7]) return char_unit({8'h00, b}, fin, r);
      return stop_unit(fin, r);
    end
    // Continuation byte
    if ((b & CONT_MASK) != CONT_PAT) return stop_unit(fin, r);
    if (seq_pend >= PEND_TWO) begin
      seq_part = seq_part | {4'h0, b[5:0], 6'b000000};
      seq_pend = PEND_ONE;
      if (fin) return stop_unit(fin, r);
      return 1'b0;
    end
    return char_unit(seq_part | {10'b0, b[5:0]}, fin, r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] data, input logic fin);
    byte_xact_t x;
    x.data = data;
    x.fin = fin;
    x.known = 1'b0;
    x.want = '0;
    x.drain_first = 1'b0;
    byte_q.insert(byte_q.size(), x);
  endfunction

  function automatic void add_known(input logic [7:0] data, input logic fin,
                                    input logic [15:0] code, input logic cv,
                                    input logic se, input logic st);
    add_byte(data, fin);
    byte_q[byte_q.size() - 1].known = 1'b1;
    byte_q[byte_q.size() - 1].want =
        '{code_unit: code, char_valid: cv, string_end: se, stopped: st};
  endfunction

  task automatic load_directed();
    add_known(8'h41, 1'b1, 16'h0041, 1'b1, 1'b1, 1'b0);  // plain ASCII right after reset
    add_known(8'h7F, 1'b0, 16'h007F, 1'b1, 1'b0, 1'b0);  // largest one-byte value
    add_known(8'h00, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1);  // zero value stops
    add_byte(8'h55, 1'b1);                               // ignored, ends the string
    add_byte(8'hC2, 1'b0);
    add_byte(8'hA9, 1'b1);
    add_byte(8'hDF, 1'b0);                               // largest two-byte value
    add_byte(8'hBF, 1'b1);
    add_byte(8'hE0, 1'b0);                               // overlong three-byte zero
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b1);                               // ignored while halted
    add_byte(8'hEF, 1'b0);                               // largest three-byte value
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b1);
    add_known(8'h80, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1);  // stray continuation as lead
    add_known(8'hF0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1);  // four-byte lead unsupported
    add_byte(8'h20, 1'b1);
    add_byte(8'hC3, 1'b0);                               // bad continuation
    add_byte(8'h41, 1'b0);
    add_byte(8'h00, 1'b1);
    add_known(8'hC3, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1);  // two-byte lead cut off
    add_byte(8'hE2, 1'b0);                               // three-byte cut after one cont
    add_byte(8'h82, 1'b1);
    add_known(8'hE2, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1);  // three-byte lead cut off
    add_byte(8'hC0, 1'b0);                               // overlong two-byte zero
    add_byte(8'h80, 1'b1);
  endtask

  // Mostly well-formed strings with random content; some damaged or pure noise
  task automatic add_random_string();
    logic [7:0] s[$];
    int         nch;
    int         k;
    damage_e    dmg;
    nch = $urandom_range(1, 8);
    for (k = 0; k < nch; k++) begin
      case ($urandom_range(0, 2))
        0: s.insert(s.size(), 8'($urandom_range(1, 127)));
        1: begin
          s.insert(s.size(), {3'b110, 5'($urandom)});
          s.insert(s.size(), {2'b10, 6'($urandom)});
        end
        default: begin
          s.insert(s.size(), {4'b1110, 4'($urandom)});
          s.insert(s.size(), {2'b10, 6'($urandom)});
          s.insert(s.size(), {2'b10, 6'($urandom)});
        end
      endcase
    end
    if ($urandom_range(0, 3) != 0) dmg = DAMAGE_NONE;
    else dmg = damage_e'($urandom_range(1, 4));
    case (dmg)
      DAMAGE_SWAP:  s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
      DAMAGE_CUT:   if (s.size() > 1) void'(s.pop_back());
      DAMAGE_ZERO:  s.insert($urandom_range(0, s.size() - 1), 8'h00);
      DAMAGE_NOISE: begin
        s.delete();
        repeat ($urandom_range(1, 6)) s.insert(s.size(), 8'($urandom));
      end
      default: ;
    endcase
    for (k = 0; k < s.size(); k++) add_byte(s[k], k == s.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    int n;
    int directed_len;
    bit calm;
    load_directed();
    directed_len = byte_q.size();
    while (byte_q.size() < directed_len + RANDOM_BYTES) add_random_string();
    byte_q[directed_len + DRAIN_OFFSET].drain_first = 1'b1;
    calm = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    for (i = 0; i < byte_q.size(); i++) begin
      // Pause until every expected result has been taken
      if (byte_q[i].drain_first) begin
        valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_units.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 63) == 0) calm = !calm;
      n = calm ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        valid_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      valid_i      <= 1'b1;
      data_byte_i  <= byte_q[i].data;
      final_byte_i <= byte_q[i].fin;
      @(posedge clk_i);
      while (stall_o) @(posedge clk_i);
    end
    valid_i  <= 1'b0;
    all_sent = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    bit calm;
    bit held;
    calm = 1'b0;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      if (!held && units_seen >= HOLD_AFTER_UNITS) begin
        held = 1'b1;
        n = HOLD_CYCLES;
      end else begin
        n = calm ? 0 : $urandom_range(0, 15);
      end
      if (n > 0) begin
        stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      @(posedge clk_i);
      while (!(valid_o && !stall_i)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: predict on each byte transaction, compare each result transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dec_result_t got;
    dec_result_t want;
    dec_result_t pred;
    bit          has;
    bit          was_halted;
    bit          moved;
    if (!rst_ni) begin
      seq_pend   = PEND_NONE;
      seq_part   = '0;
      seq_halted = 1'b0;
    end else begin
      moved = 1'b0;
      if (valid_o && !stall_i) begin
        moved = 1'b1;
        got.code_unit  = code_unit_o;
        got.char_valid = char_valid_o;
        got.string_end = string_end_o;
        got.stopped    = stopped_o;
        units_seen++;
        if (pending_units.size() == 0) begin
          err_count++;
          $error("unexpected result: code_unit %h char_valid %b string_end %b stopped %b",
                 got.code_unit, got.char_valid, got.string_end, got.stopped);
        end else begin
          want = pending_units.pop_front();
          if (got.code_unit !== want.code_unit) begin
            err_count++;
            $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
          end
          if (got.char_valid !== want.char_valid) begin
            err_count++;
            $error("char_valid: expected %b, got %b", want.char_valid, got.char_valid);
          end
          if (got.string_end !== want.string_end) begin
            err_count++;
            $error("string_end: expected %b, got %b", want.string_end, got.string_end);
          end
          if (got.stopped !== want.stopped) begin
            err_count++;
            $error("stopped: expected %b, got %b", want.stopped, got.stopped);
          end
        end
      end
      if (valid_i && stall_o) backpressure_cycles++;
      if (valid_i && !stall_o) begin
        moved = 1'b1;
        was_halted = seq_halted;
        has = decode_step(data_byte_i, final_byte_i, pred);
        if (byte_q[bytes_taken].known) begin
          pending_units.insert(pending_units.size(), byte_q[bytes_taken].want);
        end else if (has) begin
          pending_units.insert(pending_units.size(), pred);
        end
        if (has && pred.char_valid) chars_seen++;
        if (has && pred.stopped) stops_seen++;
        if (was_halted) ignored_seen++;
        bytes_taken++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: too long without any transaction
  initial begin
    wait (rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // End of run
  initial begin
    wait (all_sent);
    @(posedge clk_i);
    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d bytes: %0d characters, %0d stops, %0d bytes skipped after a stop.",
             bytes_taken, chars_seen, stops_seen, ignored_seen);
    $display("Input was held back for %0d cycles; %0d errors.", backpressure_cycles, err_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
